@@ sv/pcxd_pkg.sv @@
package pcxd_pkg;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_READY  = 3'd1;
	localparam logic [2:0] ST_BAD_MARKER = 3'd2;
	localparam logic [2:0] ST_BAD_HEADER = 3'd3;
	localparam logic [2:0] ST_CLIPPED    = 3'd4;

	// file format constants
	localparam logic [7:0] PCX_VERSION = 8'd5;
	localparam logic [7:0] PCX_BPP     = 8'd8;
	localparam logic [7:0] PCX_MARKER  = 8'd12;
	localparam logic [6:0] HDR_LAST    = 7'd127;
	localparam logic [7:0] PAL_LAST    = 8'd255;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic fetch;
		logic run_wr;
		logic chk;
		logic out_load;
	} pcxd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hdr_last;
		logic run_go;
		logic ready;
		logic cnt_last;
		logic hit;
		logic cand_last;
		logic out_free;
	} pcxd_stat_t;

endpackage

@@ sv/pcxd_ctrl.sv @@
module pcxd_ctrl import pcxd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       command,
	input  pcxd_stat_t stat,
	output logic       in_stall,
	output pcxd_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RUN,
		S_CHK,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (command == CMD_LOAD) begin
						cmd.load = 1'b1;
						if (stat.hdr_last) begin
							state_d = S_SETUP;
						end else if (stat.run_go) begin
							state_d = S_RUN;
						end
					end else if (stat.ready) begin
						cmd.fetch = 1'b1;
						state_d   = S_CHK;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_SETUP: begin
				state_d = S_IDLE;
			end
			S_RUN: begin
				cmd.run_wr = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (stat.hit || stat.cand_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/pcxd_dp.sv @@
module pcxd_dp import pcxd_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_value,
	input  pcxd_cmd_t  cmd,
	input  logic       out_stall,
	output pcxd_stat_t stat,
	output logic       out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha,
	output logic       last_pixel,
	output logic [2:0] status,
	output logic [8:0] image_width,
	output logic [8:0] image_height
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_MARKER,
		PH_PALETTE,
		PH_READY,
		PH_FAILED
	} phase_t;

	// neighbor candidates in search order
	localparam logic [2:0] C_CENTER = 3'd0;
	localparam logic [2:0] C_RIGHT  = 3'd1;
	localparam logic [2:0] C_LEFT   = 3'd2;
	localparam logic [2:0] C_BELOW  = 3'd3;
	localparam logic [2:0] C_ABOVE  = 3'd4;

	phase_t          phase_q;
	logic [6:0]      bcnt_q;
	logic [15:0]     corner_q [4];
	logic [2:0]      err_q;
	logic [AW:0]     fill_q;
	logic [5:0]      run_q;
	logic [5:0]      cnt_q;
	logic [7:0]      val_q;
	logic [7:0]      ent_q;
	logic [1:0]      comp_q;
	logic [15:0]     rg_q;
	logic [WW-1:0]   w_q;
	logic [HW-1:0]   h_q;
	logic [AW:0]     total_q;
	logic [XW-1:0]   x_q;
	logic [YW-1:0]   y_q;
	logic [AW-1:0]   pos_q;
	logic [2:0]      cand_q;
	logic            hit_q;
	logic            opaque_q;
	logic            out_valid_q;
	logic [7:0]      idx_rd_q;
	logic [23:0]     pal_rd_q;
	logic [7:0]      red_q, green_q, blue_q, alpha_q;
	logic            last_q;
	logic [2:0]      status_q;
	logic [8:0]      iw_q, ih_q;

	logic [7:0]      idx_mem [DEPTH];
	logic [23:0]     pal_mem [256];

	logic [16:0]     w17, h17;
	logic            hdr_bad;
	logic [WW+HW-1:0] prod;
	logic [AW:0]     left;
	logic [AW:0]     fill_inc;
	logic [WW-1:0]   w_m1;
	logic [HW-1:0]   h_m1;
	logic            x_last, y_last, x_first, y_first;
	logic [2:0]      cand_next;
	logic [AW-1:0]   rd_addr;
	logic            avail;
	logic            hit;
	logic            idx_re;
	logic            idx_we;
	logic [7:0]      idx_wd;

	// header size checks
	assign w17 = {1'b0, corner_q[2]} - {1'b0, corner_q[0]} + 17'd1;
	assign h17 = {1'b0, corner_q[3]} - {1'b0, corner_q[1]} + 17'd1;
	assign hdr_bad = (err_q != ST_OK) || (corner_q[2] < corner_q[0])
		|| (corner_q[3] < corner_q[1]) || (w17 > 17'(MAX_WIDTH))
		|| (h17 > 17'(MAX_HEIGHT));

	assign prod     = w_q * h_q;
	assign left     = total_q - fill_q;
	assign fill_inc = fill_q + 1'b1;

	// position in the raster
	assign w_m1    = w_q - 1'b1;
	assign h_m1    = h_q - 1'b1;
	assign x_last  = (WW'(x_q) == w_m1);
	assign y_last  = (HW'(y_q) == h_m1);
	assign x_first = (x_q == '0);
	assign y_first = (y_q == '0);

	// candidate address select
	assign cand_next = cmd.fetch ? C_CENTER : (cand_q + 3'd1);
	always_comb begin
		unique case (cand_next)
			C_RIGHT: rd_addr = pos_q + 1'b1;
			C_LEFT:  rd_addr = pos_q - 1'b1;
			C_BELOW: rd_addr = pos_q + AW'(w_q);
			C_ABOVE: rd_addr = pos_q - AW'(w_q);
			default: rd_addr = pos_q;
		endcase
	end

	// neighbor exists for the candidate just read
	always_comb begin
		unique case (cand_q)
			C_CENTER: avail = 1'b1;
			C_RIGHT:  avail = !x_last;
			C_LEFT:   avail = !x_first;
			C_BELOW:  avail = !y_last;
			C_ABOVE:  avail = !y_first;
			default:  avail = 1'b0;
		endcase
	end

	assign hit    = avail && (idx_rd_q != 8'd0);
	assign idx_re = cmd.fetch || cmd.chk;

	// index store write: literal bytes and run expansion
	assign idx_we = (cmd.load && phase_q == PH_PIXELS && run_q == '0
		&& !(byte_value[7:6] == 2'b11 && byte_value[5:0] != '0)) || cmd.run_wr;
	assign idx_wd = cmd.run_wr ? val_q : byte_value;

	always_ff @(posedge clk) begin
		if (idx_we) begin
			idx_mem[fill_q[AW-1:0]] <= idx_wd;
		end
		if (idx_re) begin
			idx_rd_q <= idx_mem[rd_addr];
		end
	end

	// palette store
	always_ff @(posedge clk) begin
		if (cmd.load && phase_q == PH_PALETTE && comp_q == 2'd2) begin
			pal_mem[ent_q] <= {rg_q, byte_value};
		end
		if (cmd.chk) begin
			pal_rd_q <= pal_mem[idx_rd_q];
		end
	end

	// load and fetch control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			bcnt_q      <= '0;
			corner_q    <= '{default: '0};
			err_q       <= ST_OK;
			fill_q      <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			ent_q       <= '0;
			comp_q      <= '0;
			w_q         <= '0;
			h_q         <= '0;
			total_q     <= '0;
			x_q         <= '0;
			y_q         <= '0;
			pos_q       <= '0;
			cand_q      <= C_CENTER;
			hit_q       <= 1'b0;
			opaque_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			total_q <= (AW + 1)'(prod);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				unique case (phase_q)
					PH_HEADER: begin
						if (bcnt_q == 7'd1 && byte_value != PCX_VERSION) begin
							err_q <= ST_BAD_HEADER;
						end
						if (bcnt_q == 7'd3 && byte_value != PCX_BPP) begin
							err_q <= ST_BAD_HEADER;
						end
						if (bcnt_q >= 7'd4 && bcnt_q <= 7'd11) begin
							if (bcnt_q[0]) begin
								corner_q[bcnt_q[2:1] - 2'd2][15:8] <= byte_value;
							end else begin
								corner_q[bcnt_q[2:1] - 2'd2][7:0] <= byte_value;
							end
						end
						bcnt_q <= bcnt_q + 1'b1;
						if (bcnt_q == HDR_LAST) begin
							if (hdr_bad) begin
								err_q   <= ST_BAD_HEADER;
								phase_q <= PH_FAILED;
							end else begin
								w_q     <= WW'(w17);
								h_q     <= HW'(h17);
								phase_q <= PH_PIXELS;
							end
						end
					end
					PH_PIXELS: begin
						if (run_q != '0) begin
							if (left < (AW + 1)'(run_q)) begin
								cnt_q <= left[5:0];
								err_q <= ST_CLIPPED;
							end else begin
								cnt_q <= run_q;
							end
							run_q <= '0;
						end else if (byte_value[7:6] == 2'b11 && byte_value[5:0] != '0) begin
							run_q <= byte_value[5:0];
						end else begin
							fill_q <= fill_inc;
							if (fill_inc == total_q) begin
								phase_q <= PH_MARKER;
							end
						end
					end
					PH_MARKER: begin
						if (byte_value != PCX_MARKER) begin
							err_q   <= ST_BAD_MARKER;
							phase_q <= PH_FAILED;
						end else begin
							ent_q   <= '0;
							comp_q  <= '0;
							phase_q <= PH_PALETTE;
						end
					end
					PH_PALETTE: begin
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							ent_q  <= ent_q + 1'b1;
							if (ent_q == PAL_LAST) begin
								phase_q <= PH_READY;
							end
						end else begin
							comp_q <= comp_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			// run expansion, one entry per cycle
			if (cmd.run_wr) begin
				fill_q <= fill_inc;
				cnt_q  <= cnt_q - 1'b1;
				if (fill_inc == total_q) begin
					phase_q <= PH_MARKER;
				end
			end
			// neighbor search
			if (cmd.fetch) begin
				cand_q   <= C_CENTER;
				hit_q    <= 1'b0;
				opaque_q <= 1'b0;
			end
			if (cmd.chk) begin
				cand_q   <= cand_q + 3'd1;
				hit_q    <= hit;
				opaque_q <= hit && (cand_q == C_CENTER);
			end
			// step the raster position
			if (cmd.out_load) begin
				if (phase_q == PH_READY) begin
					if (x_last && y_last) begin
						x_q   <= '0;
						y_q   <= '0;
						pos_q <= '0;
					end else if (x_last) begin
						x_q   <= '0;
						y_q   <= y_q + 1'b1;
						pos_q <= pos_q + 1'b1;
					end else begin
						x_q   <= x_q + 1'b1;
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	// palette byte assembly and val latch
	always_ff @(posedge clk) begin
		if (cmd.load && phase_q == PH_PALETTE) begin
			if (comp_q == 2'd0) begin
				rg_q[15:8] <= byte_value;
			end else if (comp_q == 2'd1) begin
				rg_q[7:0] <= byte_value;
			end
		end
		if (cmd.load && phase_q == PH_PIXELS && run_q != '0) begin
			val_q <= byte_value;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (phase_q == PH_READY) begin
				red_q    <= hit_q ? pal_rd_q[23:16] : 8'd0;
				green_q  <= hit_q ? pal_rd_q[15:8] : 8'd0;
				blue_q   <= hit_q ? pal_rd_q[7:0] : 8'd0;
				alpha_q  <= opaque_q ? 8'hff : 8'd0;
				last_q   <= x_last && y_last;
				status_q <= err_q;
				iw_q     <= 9'(w_q);
				ih_q     <= 9'(h_q);
			end else begin
				red_q    <= '0;
				green_q  <= '0;
				blue_q   <= '0;
				alpha_q  <= '0;
				last_q   <= 1'b0;
				status_q <= (phase_q == PH_FAILED) ? err_q : ST_NOT_READY;
				iw_q     <= '0;
				ih_q     <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign last_pixel   = last_q;
	assign status       = status_q;
	assign image_width  = iw_q;
	assign image_height = ih_q;

	// status toward the controller
	assign stat.hdr_last  = (phase_q == PH_HEADER) && (bcnt_q == HDR_LAST);
	assign stat.run_go    = (phase_q == PH_PIXELS) && (run_q != '0);
	assign stat.ready     = (phase_q == PH_READY);
	assign stat.cnt_last  = (cnt_q == 6'd1);
	assign stat.hit       = hit;
	assign stat.cand_last = (cand_q == C_ABOVE);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// fill never passes the image size while pixels load
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS && $past(phase_q == PH_PIXELS)) |-> (fill_q < total_q))
		else $error("fill position past image end");

	// run expansion only with entries left to write
	a_run_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_wr |-> (cnt_q != '0))
		else $error("run write with zero count");

	// a result is never loaded over one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten");

endmodule

@@ sv/pcx_rle_palette_rgba_decoder.sv @@
// 8-bit paletted RLE image decoder with RGBA output. Load transactions take the
// file one byte each: a 128-byte header, the run-coded pixel indices, the marker
// byte and 768 palette bytes. Input stalls while a transaction is busy: a run
// byte is followed by one index write per cycle (up to 63, one index memory
// write port), and the last header byte adds a setup state. Fetch
// transactions then return pixels in raster order and wrap after the last one.
// With the single read port of the index memory, the pixel and then up to four
// neighbors (right, left, below, above) are read one per cycle until an opaque
// index gives the color of a transparent pixel. A fetch before the palette is
// complete returns only a status code. The result register holds one finished
// pixel, so loads continue while it waits to be taken.
module pcx_rle_palette_rgba_decoder import pcxd_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha,
	output logic       last_pixel,
	output logic [2:0] status,
	output logic [8:0] image_width,
	output logic [8:0] image_height
);

	pcxd_cmd_t  cmd;
	pcxd_stat_t stat;

	// sequencing
	pcxd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// memories, counters and result register
	pcxd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_value   (byte_value),
		.cmd          (cmd),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.last_pixel   (last_pixel),
		.status       (status),
		.image_width  (image_width),
		.image_height (image_height)
	);

endmodule

@@ tb/pcx_rle_palette_rgba_decoder_tb.sv @@
module pcx_rle_palette_rgba_decoder_tb;
	import pcxd_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_pixel;
		logic [2:0] status;
		logic [8:0] image_width;
		logic [8:0] image_height;
	} pixel_t;

	typedef enum int unsigned {
		LD_HEADER, LD_PIXELS, LD_MARKER, LD_PALETTE, LD_READY, LD_FAILED
	} load_phase_t;

	// predicts the pixel stream of the decoder and checks it
	class rgba_predictor;
		logic [7:0]  idx_mem [65536];
		logic [23:0] pal_mem [256];
		load_phase_t phase;
		int unsigned hdr_count, corner [4], fill_pos, run_len, rd_pos, err_code;
		pixel_t      pending_pixels [$];
		int unsigned errors;

		function new();
			phase = LD_HEADER;
			hdr_count = 0;
			foreach (corner[i]) corner[i] = 0;
			fill_pos = 0;
			run_len = 0;
			rd_pos = 0;
			err_code = ST_OK;
			errors = 0;
		endfunction

		function int unsigned width_of();
			return (corner[2] - corner[0] + 1) & 32'h1ffff;
		endfunction

		function int unsigned height_of();
			return (corner[3] - corner[1] + 1) & 32'h1ffff;
		endfunction

		function void put_index(logic [7:0] v);
			if (fill_pos < 65536) idx_mem[fill_pos] = v;
			fill_pos++;
		endfunction

		function logic [7:0] index_at(int unsigned x, int unsigned y, int unsigned w);
			int unsigned a;
			a = y * w + x;
			if (a >= 65536) return 8'd0;
			return idx_mem[a];
		endfunction

		function void load_byte(logic [7:0] b);
			int unsigned k, c, total, n, left, e, s;
			case (phase)
				LD_HEADER: begin
					k = hdr_count;
					if (k == 1 && b != PCX_VERSION) err_code = ST_BAD_HEADER;
					if (k == 3 && b != PCX_BPP) err_code = ST_BAD_HEADER;
					if (k >= 4 && k <= 11) begin
						c = (k - 4) >> 1;
						if (k[0] == 1'b0) corner[c] = (corner[c] & 32'hff00) | b;
						else corner[c] = (corner[c] & 32'h00ff) | (32'(b) << 8);
					end
					hdr_count++;
					if (k == 127) begin
						hdr_count = 0;
						if (err_code != ST_OK || corner[2] < corner[0] || corner[3] < corner[1]
							|| width_of() > 256 || height_of() > 256) begin
							err_code = ST_BAD_HEADER;
							phase = LD_FAILED;
						end else begin
							phase = LD_PIXELS;
						end
					end
				end
				LD_PIXELS: begin
					total = width_of() * height_of();
					if (run_len != 0) begin
						n = run_len;
						left = total - fill_pos;
						if (n > left) begin
							n = left;
							err_code = ST_CLIPPED;
						end
						repeat (n) put_index(b);
						run_len = 0;
					end else if (b[7:6] == 2'b11 && b[5:0] != 0) begin
						run_len = b[5:0];
					end else begin
						put_index(b);
					end
					if (fill_pos >= total) phase = LD_MARKER;
				end
				LD_MARKER: begin
					if (b != PCX_MARKER) begin
						err_code = ST_BAD_MARKER;
						phase = LD_FAILED;
					end else begin
						phase = LD_PALETTE;
						hdr_count = 0;
					end
				end
				LD_PALETTE: begin
					e = (hdr_count / 3) & 8'hff;
					s = (2 - hdr_count % 3) * 8;
					pal_mem[e] = (pal_mem[e] & ~(24'hff << s)) | (24'(b) << s);
					hdr_count++;
					if (hdr_count >= 768) begin
						hdr_count = 0;
						phase = LD_READY;
					end
				end
				default: ;
			endcase
		endfunction

		// one accepted input transaction
		function void note_transaction(logic cmd, logic [7:0] b);
			pixel_t p;
			int unsigned w, h, x, y;
			logic [7:0] v;
			logic [23:0] rgb;
			if (cmd == CMD_LOAD) begin
				load_byte(b);
				return;
			end
			p = '0;
			if (phase != LD_READY) begin
				p.status = (phase == LD_FAILED) ? err_code[2:0] : ST_NOT_READY;
				pending_pixels.push_back(p);
				return;
			end
			w = width_of();
			h = height_of();
			if (rd_pos >= w * h) rd_pos = 0;
			x = rd_pos % w;
			y = rd_pos / w;
			v = index_at(x, y, w);
			rgb = '0;
			if (v != 0) begin
				rgb = pal_mem[v];
				p.alpha = 8'hff;
			end else if (x + 1 < w && index_at(x + 1, y, w) != 0) begin
				rgb = pal_mem[index_at(x + 1, y, w)];
			end else if (x > 0 && index_at(x - 1, y, w) != 0) begin
				rgb = pal_mem[index_at(x - 1, y, w)];
			end else if (y + 1 < h && index_at(x, y + 1, w) != 0) begin
				rgb = pal_mem[index_at(x, y + 1, w)];
			end else if (y > 0 && index_at(x, y - 1, w) != 0) begin
				rgb = pal_mem[index_at(x, y - 1, w)];
			end
			p.last_pixel = (rd_pos + 1 == w * h);
			rd_pos = p.last_pixel ? 0 : rd_pos + 1;
			{p.red, p.green, p.blue} = rgb;
			p.status = err_code[2:0];
			p.image_width = w[8:0];
			p.image_height = h[8:0];
			pending_pixels.push_back(p);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		// one accepted result transaction
		function void check_pixel(pixel_t act);
			pixel_t exp_p;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, act);
				errors++;
				return;
			end
			exp_p = pending_pixels.pop_front();
			compare_field("red", exp_p.red, act.red);
			compare_field("green", exp_p.green, act.green);
			compare_field("blue", exp_p.blue, act.blue);
			compare_field("alpha", exp_p.alpha, act.alpha);
			compare_field("last_pixel", exp_p.last_pixel, act.last_pixel);
			compare_field("status", exp_p.status, act.status);
			compare_field("image_width", exp_p.image_width, act.image_width);
			compare_field("image_height", exp_p.image_height, act.image_height);
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = CMD_LOAD;
	logic [7:0] byte_value = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] red, green, blue, alpha;
	logic       last_pixel;
	logic [2:0] status;
	logic [8:0] image_width, image_height;

	rgba_predictor model = new();
	logic [7:0]  file_bytes [$];
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	int unsigned cycles = 0;

	pcx_rle_palette_rgba_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .byte_value(byte_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.last_pixel(last_pixel), .status(status),
		.image_width(image_width), .image_height(image_height)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// input and output monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) model.note_transaction(command, byte_value);
		if (arst_n && out_valid && !out_stall)
			model.check_pixel({red, green, blue, alpha, last_pixel, status,
				image_width, image_height});
	end

	// receiver stall pattern: open, light, medium and heavy stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= $urandom_range(0, 1);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// one input transaction, then maybe a gap between bursts
	task send_item(logic cmd, logic [7:0] b);
		in_valid <= 1'b1;
		command <= cmd;
		byte_value <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function logic [7:0] random_index();
		return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
	endfunction

	// builds a whole file, possibly with one defect
	task build_file();
		int unsigned defect, w, h, xmin, ymin, xmax, ymax, total, filled, left, n;
		logic [7:0] v;
		defect = $urandom_range(0, 11);
		case ($urandom_range(0, 5))
			0: begin w = 256; h = 1; end
			1: begin w = 1; h = 256; end
			2: begin w = 1; h = 1; end
			default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
		endcase
		if (defect == 2) begin
			w = 257;
			h = 1;
		end
		xmin = $urandom_range(0, 65535 - w);
		ymin = $urandom_range(0, 65535 - h);
		xmax = xmin + w - 1;
		ymax = ymin + h - 1;
		if (defect == 3) begin
			xmin = $urandom_range(1, 65535);
			xmax = $urandom_range(0, xmin - 1);
		end
		file_bytes.delete();
		for (int i = 0; i < 128; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
		file_bytes[1] = (defect == 0) ? 8'd4 : PCX_VERSION;
		file_bytes[3] = (defect == 1) ? 8'd1 : PCX_BPP;
		file_bytes[4] = xmin[7:0];
		file_bytes[5] = xmin[15:8];
		file_bytes[6] = ymin[7:0];
		file_bytes[7] = ymin[15:8];
		file_bytes[8] = xmax[7:0];
		file_bytes[9] = xmax[15:8];
		file_bytes[10] = ymax[7:0];
		file_bytes[11] = ymax[15:8];
		// run-coded indices
		total = w * h;
		filled = 0;
		while (filled < total) begin
			left = total - filled;
			v = random_index();
			if (defect == 5 && left <= 40) begin
				n = $urandom_range(left + 1, 63);
				file_bytes.push_back(8'hc0 | 8'(n));
				file_bytes.push_back(v);
				filled = total;
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, (left < 63) ? left : 63);
				file_bytes.push_back(8'hc0 | 8'(n));
				file_bytes.push_back(v);
				filled += n;
			end else begin
				if (v[7:6] == 2'b11 && v[5:0] != 0) file_bytes.push_back(8'hc1);
				file_bytes.push_back(v);
				filled++;
			end
		end
		file_bytes.push_back((defect == 4) ? 8'd13 : PCX_MARKER);
		for (int i = 0; i < 768; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// fetches before anything is loaded
		repeat (4) send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
		build_file();
		// the file with fetches mixed in
		foreach (file_bytes[i]) begin
			if ($urandom_range(0, 15) == 0) send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
			send_item(CMD_LOAD, file_bytes[i]);
		end
		// pixel stream, with loads that must be ignored
		repeat (300) begin
			if ($urandom_range(0, 9) == 0) send_item(CMD_LOAD, 8'($urandom_range(0, 255)));
			else send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;
		while (model.pending_pixels.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (model.errors == 0 && model.pending_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/pcxd_pkg.sv
sv/pcxd_ctrl.sv
sv/pcxd_dp.sv
sv/pcx_rle_palette_rgba_decoder.sv
tb/pcx_rle_palette_rgba_decoder_tb.sv
